// ----- rtl/srr_pkg.sv -----
// Package for the slice range resolver: status codes, register indexes,
// queue sizing and the queue status struct. No dependencies.
package srr_pkg;

    localparam int DEF_POS_BITS = 32;

    // status codes
    localparam logic [3:0] ST_OK              = 4'd0;
    localparam logic [3:0] ST_START_ZERO      = 4'd1;
    localparam logic [3:0] ST_END_ZERO        = 4'd2;
    localparam logic [3:0] ST_BAD_START_END   = 4'd3;
    localparam logic [3:0] ST_NEG_COUNT       = 4'd4;
    localparam logic [3:0] ST_NA_PATTERN      = 4'd5;
    localparam logic [3:0] ST_BAD_END_COUNT   = 4'd6;
    localparam logic [3:0] ST_BAD_START_COUNT = 4'd7;
    localparam logic [3:0] ST_BEFORE_START    = 4'd8;
    localparam logic [3:0] ST_NEG_LENGTH      = 4'd9;
    localparam logic [3:0] ST_PAST_END        = 4'd10;

    localparam int STATUS_W = 4;

    // register indexes (byte address = 4 * index)
    localparam int         REG_IDX_W = 2;
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_END   = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // queue between the front and the back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int OUT_START_W = 32;
    localparam int OUT_COUNT_W = 31;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 64;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- rtl/srr_cfg_regs.sv -----
// Configuration registers for the slice range resolver, APB-style port.
// Depends on srr_pkg.
module srr_cfg_regs
    import srr_pkg::*;
#(
    parameter int POS_BITS = DEF_POS_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [APB_AW-1:0]   i_paddr,
    input  logic [APB_DW-1:0]   i_pwdata,
    output logic [APB_DW-1:0]   o_prdata,
    output logic [POS_BITS-1:0] o_start_setting,
    output logic [POS_BITS-1:0] o_end_setting,
    output logic [POS_BITS-1:0] o_count_setting
);

    localparam logic [POS_BITS-1:0] MISSING = {1'b1, {(POS_BITS-1){1'b0}}};

    logic [POS_BITS-1:0]  r_start;
    logic [POS_BITS-1:0]  r_end;
    logic [POS_BITS-1:0]  r_count;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign wr_en = i_psel & i_penable & i_pwrite;
    assign idx   = i_paddr[REG_IDX_W+1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= MISSING;
            r_end   <= MISSING;
            r_count <= MISSING;
        end else if (wr_en) begin
            unique case (idx)
                REG_START: r_start <= i_pwdata[POS_BITS-1:0];
                REG_END:   r_end   <= i_pwdata[POS_BITS-1:0];
                REG_COUNT: r_count <= i_pwdata[POS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_START: o_prdata = APB_DW'(r_start);
            REG_END:   o_prdata = APB_DW'(r_end);
            REG_COUNT: o_prdata = APB_DW'(r_count);
            default:   o_prdata = '0;
        endcase
    end

    assign o_start_setting = r_start;
    assign o_end_setting   = r_end;
    assign o_count_setting = r_count;

endmodule

// ----- rtl/srr_front.sv -----
// Front end: resolves the start/end/count settings into a start and end
// and a configuration status, and prepares length+1 for the back end.
// Depends on srr_pkg.
module srr_front
    import srr_pkg::*;
#(
    parameter int POS_BITS = DEF_POS_BITS,
    parameter int W        = POS_BITS + 2
) (
    input  logic                  [POS_BITS-1:0] i_start_setting,
    input  logic                  [POS_BITS-1:0] i_end_setting,
    input  logic                  [POS_BITS-1:0] i_count_setting,
    input  logic                  [POS_BITS-2:0] i_seq_len,
    output logic                  [STATUS_W-1:0] o_status,
    output logic signed           [W-1:0]        o_rs,
    output logic signed           [W-1:0]        o_re,
    output logic signed           [W-1:0]        o_len_p1
);

    localparam logic [POS_BITS-1:0] MISSING   = {1'b1, {(POS_BITS-1){1'b0}}};
    localparam logic signed [W-1:0] S_ONE     = W'(1);
    localparam logic signed [W-1:0] S_NEG_ONE = W'(-1);
    localparam logic signed [W-1:0] S_ZERO    = '0;

    logic                s_na, e_na, c_na;
    logic signed [W-1:0] s, e, c, s_adj, e_adj;

    assign s_na = (i_start_setting == MISSING);
    assign e_na = (i_end_setting == MISSING);
    assign c_na = (i_count_setting == MISSING);
    assign s    = W'(signed'(i_start_setting));
    assign e    = W'(signed'(i_end_setting));
    assign c    = W'(signed'(i_count_setting));
    // with no count, missing bounds default to the whole sequence
    assign s_adj = s_na ? S_ONE : s;
    assign e_adj = e_na ? S_NEG_ONE : e;

    assign o_len_p1 = signed'(W'(i_seq_len)) + S_ONE;

    always_comb begin
        o_status = ST_OK;
        o_rs     = s_adj;
        o_re     = e_adj;
        if (s == S_ZERO) begin
            o_status = ST_START_ZERO;
        end else if (e == S_ZERO) begin
            o_status = ST_END_ZERO;
        end else if (c_na) begin
            if ((e_adj > S_ZERO || s_adj < S_ZERO) && e_adj < s_adj) begin
                o_status = ST_BAD_START_END;
            end
        end else if (c < S_ZERO) begin
            o_status = ST_NEG_COUNT;
        end else if (s_na == e_na) begin
            o_status = ST_NA_PATTERN;
        end else if (s_na) begin
            if (e > S_ZERO && e < c) begin
                o_status = ST_BAD_END_COUNT;
            end else begin
                o_rs = e - c + S_ONE;
            end
        end else begin
            if (s < S_ZERO && -s < c) begin
                o_status = ST_BAD_START_COUNT;
            end else begin
                o_re = s + c - S_ONE;
            end
        end
    end

endmodule

// ----- rtl/srr_queue.sv -----
// Short FIFO between the front and back ends of the slice range resolver.
// Depends on srr_pkg.
module srr_queue
    import srr_pkg::*;
#(
    parameter int EW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [EW-1:0] i_wdata,
    input  logic          i_pop,
    output logic [EW-1:0] o_rdata,
    output t_q_stat       o_stat
);

    logic [EW-1:0]  r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QAW:0]   r_count, n_count;
    logic           do_push, do_pop;

    assign o_stat.full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push = i_push & ~o_stat.full;
    assign do_pop  = i_pop & ~o_stat.empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rd_ptr];

endmodule

// ----- rtl/srr_back.sv -----
// Back end: applies one sequence's length to the resolved range, checks it
// and holds the result in the output register. Depends on srr_pkg.
module srr_back
    import srr_pkg::*;
#(
    parameter int POS_BITS = DEF_POS_BITS,
    parameter int W        = POS_BITS + 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  logic [STATUS_W-1:0]    i_status,
    input  logic signed [W-1:0]    i_rs,
    input  logic signed [W-1:0]    i_re,
    input  logic signed [W-1:0]    i_len_p1,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_START_W-1:0] o_start_pos,
    output logic [OUT_COUNT_W-1:0] o_letter_count,
    output logic [STATUS_W-1:0]    o_status
);

    localparam logic signed [W-1:0] S_ONE  = W'(1);
    localparam logic signed [W-1:0] S_ZERO = '0;

    logic                   r_valid;
    logic [OUT_START_W-1:0] r_start_pos, n_start_pos;
    logic [OUT_COUNT_W-1:0] r_letter_count, n_letter_count;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic signed [W-1:0]    s, ep, n;
    logic                   load;

    // ep is the 1-based last position, so s + n - 1 == ep
    assign s  = (i_rs <= S_ZERO) ? i_rs + i_len_p1 : i_rs;
    assign ep = (i_re < S_ZERO) ? i_re + i_len_p1 : i_re;
    assign n  = ep - s + S_ONE;

    always_comb begin
        n_status       = i_status;
        n_start_pos    = '0;
        n_letter_count = '0;
        if (i_status == ST_OK) begin
            if (s < S_ONE) begin
                n_status = ST_BEFORE_START;
            end else if (n < S_ZERO) begin
                n_status = ST_NEG_LENGTH;
            end else if (ep >= i_len_p1) begin
                n_status = ST_PAST_END;
            end else begin
                n_start_pos    = OUT_START_W'(s);
                n_letter_count = OUT_COUNT_W'(n);
            end
        end
    end

    assign load  = i_q_valid & (~r_valid | i_ready);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_start_pos    <= n_start_pos;
            r_letter_count <= n_letter_count;
            r_status       <= n_status;
        end
    end

    assign o_valid        = r_valid;
    assign o_start_pos    = r_start_pos;
    assign o_letter_count = r_letter_count;
    assign o_status       = r_status;

endmodule

// ----- rtl/slice_range_resolver.sv -----
// Top level of the slice range resolver: config registers, front end,
// queue and back end. Depends on srr_pkg and the srr_* modules.
//
// channel   | dir | handshake              | payload
// s_axis    | in  | s_axis_tvalid/tready   | tdata: seq_len
// m_axis    | out | m_axis_tvalid/tready   | tdata: start_pos, letter_count; tuser: status
// apb       | in  | psel, penable, pready  | paddr, pwdata, prdata
//
// One item per cycle sustained while m_axis_tready is high; an accepted item
// is written into the queue and then loaded into the output register.
// The 4-entry queue lets the input side keep going while a result waits.
// Reset (synchronous, active low) sets all settings to missing and empties
// the queue and output register.
module slice_range_resolver
    import srr_pkg::*;
#(
    parameter int POS_BITS = DEF_POS_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [30:0] seq_len, [31] unused
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [31:0] start_pos, [62:32] letter_count
    output logic [STATUS_W-1:0]   m_axis_tuser,  // [3:0] status
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    localparam int W  = POS_BITS + 2;
    localparam int EW = STATUS_W + 3 * W;

    logic [POS_BITS-1:0]    start_setting, end_setting, count_setting;
    logic [STATUS_W-1:0]    f_status, q_status;
    logic signed [W-1:0]    f_rs, f_re, f_len_p1, q_rs, q_re, q_len_p1;
    logic [EW-1:0]          q_wdata, q_rdata;
    t_q_stat                q_stat;
    logic                   q_pop;
    logic                   in_acc;
    logic [OUT_START_W-1:0] start_pos;
    logic [OUT_COUNT_W-1:0] letter_count;

    assign pready = 1'b1;

    srr_cfg_regs #(.POS_BITS(POS_BITS)) u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (prdata),
        .o_start_setting (start_setting),
        .o_end_setting   (end_setting),
        .o_count_setting (count_setting)
    );

    srr_front #(.POS_BITS(POS_BITS), .W(W)) u_front (
        .i_start_setting (start_setting),
        .i_end_setting   (end_setting),
        .i_count_setting (count_setting),
        .i_seq_len       (s_axis_tdata[POS_BITS-2:0]),
        .o_status        (f_status),
        .o_rs            (f_rs),
        .o_re            (f_re),
        .o_len_p1        (f_len_p1)
    );

    assign s_axis_tready = ~q_stat.full;
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign q_wdata       = {f_status, f_rs, f_re, f_len_p1};

    srr_queue #(.EW(EW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_acc),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_stat  (q_stat)
    );

    assign {q_status, q_rs, q_re, q_len_p1} = q_rdata;

    srr_back #(.POS_BITS(POS_BITS), .W(W)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (~q_stat.empty),
        .i_status       (q_status),
        .i_rs           (q_rs),
        .i_re           (q_re),
        .i_len_p1       (q_len_p1),
        .o_pop          (q_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_start_pos    (start_pos),
        .o_letter_count (letter_count),
        .o_status       (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, letter_count, start_pos};

`ifndef ASSERT_OFF
    // results with an error status carry no positions
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("nonzero payload with error status");

    // an ok result always starts at position one or later
    a_ok_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_OK) |-> (start_pos != '0))
        else $error("ok result with zero start");

    // an item entering an empty block passes the queue and reaches the output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && q_stat.empty && !m_axis_tvalid) |=> ##1 m_axis_tvalid)
        else $error("item lost between front and back");

    // nothing is presented right after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule
